/* rtl/fab_pkg.sv */
package fab_pkg;

  // Widths of the offset and size fields.
  localparam int ADDR_BITS = 24;
  localparam int SIZE_BITS = 24;

  // Defaults for the top-level parameters.
  localparam int TABLE_DEPTH_DEF  = 16;
  localparam int HEADER_BYTES_DEF = 24;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_type_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NULL       = 2'd1,
    ST_TABLE_FULL = 2'd2,
    ST_BAD_PTR    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } fsm_t;

  typedef struct packed {
    req_type_t              req_type;
    logic [SIZE_BITS-1:0]   req_size;
    logic [ADDR_BITS-1:0]   req_addr;
  } req_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0]   result_addr;
    status_t                status;
  } resp_t;

  // One row of the block table.
  typedef struct packed {
    logic [ADDR_BITS-1:0]   blk_start;
    logic [SIZE_BITS-1:0]   blk_size;
    logic                   blk_free;
  } entry_t;

endpackage

/* rtl/first_fit_block_allocator.sv */
// Steps: an allocate of size zero or a release of null skips the table scan and goes straight
// to its result; any other request scans the live entries, stopping at the first match.
// Throughput: one request at a time, set by the single read port of the block table that
// is read one entry per cycle in creation order.
// Reset: synchronous; clears the block count and break offset and sets the heap limit to its
// maximum. The table memory itself is not cleared, and no clearing pass is needed.
module first_fit_block_allocator #(
  parameter int TABLE_DEPTH  = fab_pkg::TABLE_DEPTH_DEF,
  parameter int HEADER_BYTES = fab_pkg::HEADER_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [fab_pkg::ADDR_BITS-1:0] cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  fab_pkg::req_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output fab_pkg::resp_t                out_data
);

  import fab_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int TOP_W = ADDR_BITS + 2;

  localparam logic [ADDR_BITS:0]   HB_EXT    = (ADDR_BITS + 1)'(HEADER_BYTES);
  localparam logic [TOP_W-1:0]     HB_TOP    = TOP_W'(HEADER_BYTES);
  localparam logic [TOP_W-1:0]     ADDR_MASK = {2'b00, {ADDR_BITS{1'b1}}};
  localparam logic [CNT_W-1:0]     DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  // Control state.
  fsm_t                 state, state_next;
  logic [CNT_W-1:0]     cnt, cnt_next;
  logic [ADDR_BITS-1:0] brk, brk_next;
  logic [ADDR_BITS-1:0] heap;
  logic [CNT_W-1:0]     issue_idx, issue_next;
  logic                 rvld, rvld_next;

  // Payload registers.
  req_t                 req;
  resp_t                res, res_next;
  logic [IDX_W-1:0]     ridx;
  entry_t               rd_data;

  // Table memory ports.
  entry_t               mem [TABLE_DEPTH];
  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  entry_t               wr_data;

  logic                 in_fire;
  logic                 out_load;
  logic [TOP_W-1:0]     top;
  logic                 fit_hit;
  logic                 ptr_hit;
  logic                 is_top_blk;

  assign in_fire = in_valid & in_ready;

  // Break offset after appending a block of the requested size.
  assign top = {2'b00, brk} + HB_TOP + {{(TOP_W - SIZE_BITS){1'b0}}, req.req_size};

  // Compare logic for the entry returned by the memory.
  assign fit_hit    = rd_data.blk_free && (rd_data.blk_size >= req.req_size);
  assign ptr_hit    = ({1'b0, rd_data.blk_start} + HB_EXT) == {1'b0, req.req_addr};
  assign is_top_blk = (CNT_W'(ridx) + CNT_W'(1)) == cnt;

  // The scan reads one entry per cycle while entries remain.
  assign rd_en   = (state == S_SCAN) && (issue_idx < cnt);
  assign rd_addr = issue_idx[IDX_W-1:0];

  // Block table: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // State register and control.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      brk       <= '0;
      issue_idx <= '0;
      rvld      <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      brk       <= brk_next;
      issue_idx <= issue_next;
      rvld      <= rvld_next;
    end
  end

  // Heap limit register.
  always_ff @(posedge clk) begin
    if (rst) begin
      heap <= {ADDR_BITS{1'b1}};
    end else if (cfg_we) begin
      heap <= cfg_wdata;
    end
  end

  // Request, pending result and read index.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req <= in_data;
    end
    res  <= res_next;
    ridx <= issue_idx[IDX_W-1:0];
  end

  // Output register parts the result from the scan.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_load | (out_valid & ~out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= res;
    end
  end

  // Next state, table updates and result.
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    brk_next   = brk;
    issue_next = issue_idx;
    rvld_next  = 1'b0;
    res_next   = res;
    wr_en      = 1'b0;
    wr_addr    = cnt[IDX_W-1:0];
    wr_data    = rd_data;
    in_ready   = 1'b0;
    out_load   = 1'b0;

    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          issue_next = '0;
          if (in_data.req_type == REQ_ALLOC && in_data.req_size == '0) begin
            res_next   = '{result_addr: '0, status: ST_NULL};
            state_next = S_DONE;
          end else if (in_data.req_type == REQ_FREE && in_data.req_addr == '0) begin
            res_next   = '{result_addr: '0, status: ST_OK};
            state_next = S_DONE;
          end else begin
            state_next = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (rd_en) begin
          issue_next = issue_idx + CNT_W'(1);
          rvld_next  = 1'b1;
        end
        if (rvld && req.req_type == REQ_ALLOC && fit_hit) begin
          // Reuse the first free block that is large enough.
          wr_en            = 1'b1;
          wr_addr          = ridx;
          wr_data          = rd_data;
          wr_data.blk_free = 1'b0;
          res_next = '{result_addr: ADDR_BITS'({1'b0, rd_data.blk_start} + HB_EXT),
                       status: ST_OK};
          rvld_next  = 1'b0;
          state_next = S_DONE;
        end else if (rvld && req.req_type == REQ_FREE && ptr_hit) begin
          // The topmost block is removed; any other is only marked free.
          if (is_top_blk) begin
            brk_next = rd_data.blk_start;
            cnt_next = cnt - CNT_W'(1);
          end else begin
            wr_en            = 1'b1;
            wr_addr          = ridx;
            wr_data          = rd_data;
            wr_data.blk_free = 1'b1;
          end
          res_next   = '{result_addr: '0, status: ST_OK};
          rvld_next  = 1'b0;
          state_next = S_DONE;
        end else if (!rvld && !rd_en) begin
          // The whole table has been searched without a match.
          if (req.req_type == REQ_FREE) begin
            res_next = '{result_addr: '0, status: ST_BAD_PTR};
          end else if (top > {2'b00, heap} || top > ADDR_MASK) begin
            res_next = '{result_addr: '0, status: ST_NULL};
          end else if (cnt >= DEPTH_CNT) begin
            res_next = '{result_addr: '0, status: ST_TABLE_FULL};
          end else begin
            wr_en    = 1'b1;
            wr_addr  = cnt[IDX_W-1:0];
            wr_data  = '{blk_start: brk, blk_size: req.req_size, blk_free: 1'b0};
            cnt_next = cnt + CNT_W'(1);
            brk_next = top[ADDR_BITS-1:0];
            res_next = '{result_addr: ADDR_BITS'({1'b0, brk} + HB_EXT), status: ST_OK};
          end
          state_next = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  // The table never holds more blocks than it has rows.
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= DEPTH_CNT)
    else $error("block count exceeds table depth");

  // The block count moves by at most one per cycle.
  a_cnt_step: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (cnt == $past(cnt) || cnt == $past(cnt) + CNT_W'(1) ||
              cnt == $past(cnt) - CNT_W'(1)))
    else $error("block count jumped");

  // Writes land on a live row or on the row just past the last one.
  a_wr_range: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (CNT_W'(wr_addr) <= cnt))
    else $error("table write beyond block count");

  // A failed request never carries an address.
  a_fail_null: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.status == ST_OK || out_data.result_addr == '0))
    else $error("failed request returned an address");
`endif

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps

// Scoreboard for the allocator: it keeps its own copy of the block table and
// the break offset, predicts one response per accepted request and compares
// responses in order.
class heap_scoreboard;
  localparam int DEPTH  = fab_pkg::TABLE_DEPTH_DEF;
  localparam int HEADER = fab_pkg::HEADER_BYTES_DEF;

  logic [fab_pkg::ADDR_BITS-1:0] blk_start [DEPTH];
  logic [fab_pkg::SIZE_BITS-1:0] blk_size  [DEPTH];
  bit                            blk_free  [DEPTH];
  int unsigned                   blk_count;
  logic [fab_pkg::ADDR_BITS-1:0] brk;
  logic [fab_pkg::ADDR_BITS-1:0] heap_limit;

  fab_pkg::resp_t expected_grants[$];
  int errors;
  int n_alloc;
  int n_release;
  int seen_status[4];

  function new();
    blk_count  = 0;
    brk        = '0;
    heap_limit = '1;
    errors     = 0;
    n_alloc    = 0;
    n_release  = 0;
    foreach (seen_status[i]) seen_status[i] = 0;
  endfunction

  function void set_heap_limit(logic [fab_pkg::ADDR_BITS-1:0] limit);
    heap_limit = limit;
  endfunction

  function int pending();
    return expected_grants.size();
  endfunction

  // Payload offset of table entry idx.
  function logic [fab_pkg::ADDR_BITS-1:0] payload_of(int unsigned idx);
    return blk_start[idx] + (fab_pkg::ADDR_BITS)'(HEADER);
  endfunction

  // Works out the response to one request and updates the table as the block would.
  function fab_pkg::resp_t allocate_or_release(fab_pkg::req_t r);
    fab_pkg::resp_t res;
    logic [fab_pkg::ADDR_BITS+1:0] top;
    bit done;
    res.result_addr = '0;
    res.status      = fab_pkg::ST_OK;
    done            = 1'b0;
    if (r.req_type == fab_pkg::REQ_ALLOC) begin
      if (r.req_size == '0) begin
        res.status = fab_pkg::ST_NULL;
      end else begin
        // First fit among the free blocks, in creation order.
        for (int unsigned i = 0; i < blk_count && !done; i++) begin
          if (blk_free[i] && blk_size[i] >= r.req_size) begin
            blk_free[i]     = 1'b0;
            res.result_addr = payload_of(i);
            done            = 1'b1;
          end
        end
        if (!done) begin
          // The heap limit never exceeds the address range, so one compare covers both.
          top = {2'b00, brk} + (fab_pkg::ADDR_BITS + 2)'(HEADER) + {2'b00, r.req_size};
          if (top > heap_limit) begin
            res.status = fab_pkg::ST_NULL;
          end else if (blk_count >= DEPTH) begin
            res.status = fab_pkg::ST_TABLE_FULL;
          end else begin
            blk_start[blk_count] = brk;
            blk_size[blk_count]  = r.req_size;
            blk_free[blk_count]  = 1'b0;
            blk_count++;
            res.result_addr = brk + (fab_pkg::ADDR_BITS)'(HEADER);
            brk             = top[fab_pkg::ADDR_BITS-1:0];
          end
        end
      end
    end else if (r.req_addr != '0) begin
      // Release: the topmost block is removed, any other is only marked free.
      for (int unsigned i = 0; i < blk_count && !done; i++) begin
        if (payload_of(i) == r.req_addr) begin
          if (i + 1 == blk_count) begin
            brk = blk_start[i];
            blk_count--;
          end else begin
            blk_free[i] = 1'b1;
          end
          done = 1'b1;
        end
      end
      if (!done) res.status = fab_pkg::ST_BAD_PTR;
    end
    return res;
  endfunction

  function void note_request(fab_pkg::req_t r);
    if (r.req_type == fab_pkg::REQ_ALLOC) n_alloc++;
    else n_release++;
    expected_grants.push_back(allocate_or_release(r));
  endfunction

  function void check_response(fab_pkg::resp_t got);
    fab_pkg::resp_t want;
    seen_status[got.status]++;
    if (expected_grants.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("ERROR: unexpected result, result_addr %h status %0d",
                 got.result_addr, got.status);
    end else begin
      want = expected_grants.pop_front();
      if (got.result_addr !== want.result_addr || got.status !== want.status) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: result_addr expected %h got %h, status expected %0d got %0d",
                   want.result_addr, got.result_addr, want.status, got.status);
      end
    end
  endfunction
endclass

module tb_top;
  import fab_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RX_HOLD_LEN  = 400;
  localparam int SETTLE       = TABLE_DEPTH_DEF + 3;
  localparam int ITEMS_PER_PH = 283;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [ADDR_BITS-1:0] cfg_wdata = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  req_t                 in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  resp_t                out_data;

  logic rx_hold = 1'b0;
  logic hold_go = 1'b0;
  int   tx_idle_pct = 6;
  int   rx_idle_pct = 48;
  int   cycles = 0;

  heap_scoreboard sb = new();

  first_fit_block_allocator u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: checks each response transfer, then picks the next ready value.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_response(out_data);
    if (rx_hold) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Long receiver hold-off, so that the block backs up and stalls its input.
  initial begin
    @(posedge hold_go);
    rx_hold <= 1'b1;
    repeat (RX_HOLD_LEN) @(posedge clk);
    rx_hold <= 1'b0;
  end

  function automatic req_t make_req(req_type_t kind, logic [SIZE_BITS-1:0] size,
                                    logic [ADDR_BITS-1:0] addr);
    req_t r;
    r.req_type = kind;
    r.req_size = size;
    r.req_addr = addr;
    return r;
  endfunction

  // Offers one request, with an occasional gap first, and notes it once transferred.
  task automatic send_request(input req_t r);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
    sb.note_request(r);
  endtask

  // Waits until every response has come back and the block has settled.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_heap_limit(input logic [ADDR_BITS-1:0] limit);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= limit;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_heap_limit(limit);
  endtask

  // Mostly well-formed traffic: small allocations and releases of live blocks,
  // with some zero sizes, oversized requests, null and stray pointers mixed in.
  function automatic req_t random_request();
    req_t r;
    int sel;
    int unsigned idx;
    r.req_type = REQ_FREE;
    r.req_size = SIZE_BITS'($urandom());
    r.req_addr = ADDR_BITS'($urandom());
    sel = $urandom_range(99);
    if (sel < 58) begin
      r.req_type = REQ_ALLOC;
      if (sel < 45) r.req_size = SIZE_BITS'($urandom_range(1, 64));
      else if (sel < 54) r.req_size = (sel < 50) ? SIZE_BITS'($urandom()) : '0;
      else r.req_size = SIZE_BITS'($urandom_range(65, 400));
    end else if (sel < 93 && sb.blk_count > 0) begin
      if (sel < 83) idx = $urandom_range(sb.blk_count - 1);
      else if (sel < 89) idx = sb.blk_count - 1;
      else idx = 0;
      r.req_addr = (sel < 89) ? sb.payload_of(idx) : '0;
    end else if (sel < 93) begin
      r.req_addr = '0;
    end else if (sel >= 97 && sb.blk_count > 0) begin
      // Near miss: one byte past a real payload offset.
      r.req_addr = sb.payload_of($urandom_range(sb.blk_count - 1)) + ADDR_BITS'(1);
    end
    return r;
  endfunction

  task automatic random_phase(input int n_items);
    for (int k = 0; k < n_items; k++) begin
      if (k == 100 && rx_idle_pct == 48) hold_go <= 1'b1;
      send_request(random_request());
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: an empty heap limit first.
    write_heap_limit('0);
    send_request(make_req(REQ_ALLOC, 24'd1, '0));
    send_request(make_req(REQ_ALLOC, '0, '0));
    send_request(make_req(REQ_FREE, '0, '0));
    send_request(make_req(REQ_FREE, '1, '1));

    // Largest limit: size extremes, the exact fit to the top, reuse and releases.
    write_heap_limit('1);
    send_request(make_req(REQ_ALLOC, '1, '0));
    send_request(make_req(REQ_ALLOC, 24'hFFFFE7, '0));
    send_request(make_req(REQ_FREE, '0, 24'd24));
    send_request(make_req(REQ_ALLOC, 24'd10, '0));
    send_request(make_req(REQ_ALLOC, 24'd20, '0));
    send_request(make_req(REQ_ALLOC, 24'd5, '0));
    send_request(make_req(REQ_FREE, '0, 24'd58));
    send_request(make_req(REQ_FREE, '0, 24'd58));
    send_request(make_req(REQ_ALLOC, 24'd15, '0));
    send_request(make_req(REQ_FREE, '0, 24'd102));
    send_request(make_req(REQ_FREE, '0, 24'd102));
    send_request(make_req(REQ_FREE, '0, 24'd25));

    // Fill the table, then ask once more.
    while (sb.blk_count < TABLE_DEPTH_DEF) send_request(make_req(REQ_ALLOC, 24'd8, '0));
    send_request(make_req(REQ_ALLOC, 24'd8, '0));

    // Limit dropped below the break: the heap check wins over the full table.
    write_heap_limit(24'd100);
    send_request(make_req(REQ_ALLOC, 24'd1, '0));

    // Random part, sender idling little and receiver much.
    write_heap_limit('1);
    random_phase(ITEMS_PER_PH);

    // Receiver idling little and sender much, with a tighter heap.
    write_heap_limit(24'd1500);
    tx_idle_pct = 48;
    rx_idle_pct = 6;
    random_phase(ITEMS_PER_PH);

    // No idling at all, tighter still.
    write_heap_limit(24'd400);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_phase(ITEMS_PER_PH);

    wait_idle();
    $display("Covered %0d requests (%0d allocate, %0d release) under heap limits",
             sb.n_alloc + sb.n_release, sb.n_alloc, sb.n_release);
    $display("of 0, 100, 400, 1500 and the maximum: %0d ok, %0d null, %0d table full,",
             sb.seen_status[ST_OK], sb.seen_status[ST_NULL], sb.seen_status[ST_TABLE_FULL]);
    $display("%0d bad pointer.", sb.seen_status[ST_BAD_PTR]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
